// ----- sv/assert_macros.svh -----
// assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define BCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge
`define BCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/bcdclk_pkg.sv -----
package bcdclk_pkg;

  localparam int KIND_W = 3;
  localparam int SEL_W  = 3;
  localparam int SEG_W  = 8;
  localparam int EN_W   = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REFRESH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TOGGLE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CURSOR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INC     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd5;

  // cursor codes and scan positions share one numbering
  localparam logic [SEL_W-1:0] POS_NONE     = 3'd0;
  localparam logic [SEL_W-1:0] POS_MIN_UNIT = 3'd1;
  localparam logic [SEL_W-1:0] POS_MIN_TEN  = 3'd2;
  localparam logic [SEL_W-1:0] POS_HR_UNIT  = 3'd3;
  localparam logic [SEL_W-1:0] POS_HR_TEN   = 3'd4;
  localparam logic [SEL_W-1:0] POS_SEC_UNIT = 3'd5;
  localparam logic [SEL_W-1:0] POS_SEC_TEN  = 3'd6;

  localparam logic [EN_W-1:0] EN_OFF  = 4'hF;
  localparam logic [EN_W-1:0] EN_POS0 = 4'hE;
  localparam logic [EN_W-1:0] EN_POS1 = 4'hD;
  localparam logic [EN_W-1:0] EN_POS2 = 4'hB;
  localparam logic [EN_W-1:0] EN_POS3 = 4'h7;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
  localparam logic [SEG_W-1:0] SEG_DOT   = 8'h7F;

  localparam logic [ADDR_W-1:0] ADDR_DOT_ALWAYS_ON = 3'd0;

  // active-low pattern of one bcd digit, blank above nine
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] value);
    logic [SEG_W-1:0] p;
    unique case (value)
      4'd0: p = 8'hC0;
      4'd1: p = 8'hF9;
      4'd2: p = 8'hA4;
      4'd3: p = 8'hB0;
      4'd4: p = 8'h99;
      4'd5: p = 8'h92;
      4'd6: p = 8'h82;
      4'd7: p = 8'hF8;
      4'd8: p = 8'h80;
      4'd9: p = 8'h90;
      default: p = SEG_BLANK;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/bcd_clock_with_mux_display.sv -----
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_stall   | kind, digit_sel
// out     | out       | out_valid/out_stall | segments, digit_enables, time digits, view_seconds
// cfg     | in        | apb psel/penable    | dot_always_on at byte address 0
//
// an item is registered on accept and processed into the result register once that is not stalled
// out_valid rises as the item is processed; one item per cycle sustained while out_stall is low
// the combinational event update (carry chain plus segment lookup) sets the rate
// in_stall rises only when an item waits in the input register and the result is stalled
// rst is synchronous: time 00:00:00, scan at minute units, seg latch blank, enable latch all off
`include "assert_macros.svh"

module bcd_clock_with_mux_display (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bcdclk_pkg::KIND_W-1:0]     kind,
  input  logic [bcdclk_pkg::SEL_W-1:0]      digit_sel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bcdclk_pkg::SEG_W-1:0]      segments,
  output logic [bcdclk_pkg::EN_W-1:0]       digit_enables,
  output logic [1:0]                        hour_tens,
  output logic [3:0]                        hour_units,
  output logic [2:0]                        minute_tens,
  output logic [3:0]                        minute_units,
  output logic [2:0]                        second_tens,
  output logic [3:0]                        second_units,
  output logic                              view_seconds,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bcdclk_pkg::ADDR_W-1:0]     paddr,
  input  logic [bcdclk_pkg::DATA_W-1:0]     pwdata,
  output logic [bcdclk_pkg::DATA_W-1:0]     prdata,
  output logic                              pready
);

  logic                          dot_always_on;
  logic                          item_valid;
  logic [bcdclk_pkg::KIND_W-1:0] item_kind;
  logic [bcdclk_pkg::SEL_W-1:0]  item_sel;
  logic                          advance;
  logic                          in_accept;

  logic [3:0] sec_units, sec_units_next;
  logic [2:0] sec_tens, sec_tens_next;
  logic [3:0] min_units, min_units_next;
  logic [2:0] min_tens, min_tens_next;
  logic [3:0] hr_units, hr_units_next;
  logic [1:0] hr_tens, hr_tens_next;
  logic [bcdclk_pkg::SEL_W-1:0] scan_pos, scan_pos_next;
  logic [bcdclk_pkg::SEL_W-1:0] cursor, cursor_next;
  logic [bcdclk_pkg::SEG_W-1:0] seg_latch, seg_latch_next;
  logic [bcdclk_pkg::EN_W-1:0]  enable_latch, enable_latch_next;

  logic [4:0] su_inc, mu_inc, hu_inc;
  logic [3:0] st_inc, mt_inc;
  logic [2:0] ht_inc;
  logic [3:0] shown;
  logic       dot;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bcdclk_pkg::ADDR_DOT_ALWAYS_ON[2])
                ? {{(bcdclk_pkg::DATA_W-1){1'b0}}, dot_always_on}
                : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_always_on <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == bcdclk_pkg::ADDR_DOT_ALWAYS_ON[2]) begin
      dot_always_on <= pwdata[0];
    end
  end

  // input register
  assign advance   = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_accept || (item_valid && !advance);
    end
    if (in_accept) begin
      item_kind <= kind;
      item_sel  <= digit_sel;
    end
  end

  // event update
  assign su_inc = {1'b0, sec_units} + 5'd1;
  assign st_inc = {1'b0, sec_tens} + 4'd1;
  assign mu_inc = {1'b0, min_units} + 5'd1;
  assign mt_inc = {1'b0, min_tens} + 4'd1;
  assign hu_inc = {1'b0, hr_units} + 5'd1;
  assign ht_inc = {1'b0, hr_tens} + 3'd1;

  always_comb begin
    sec_units_next    = sec_units;
    sec_tens_next     = sec_tens;
    min_units_next    = min_units;
    min_tens_next     = min_tens;
    hr_units_next     = hr_units;
    hr_tens_next      = hr_tens;
    scan_pos_next     = scan_pos;
    cursor_next       = cursor;
    seg_latch_next    = seg_latch;
    enable_latch_next = enable_latch;
    shown             = 4'd0;
    dot               = 1'b0;

    unique case (item_kind)
      bcdclk_pkg::KIND_TICK: begin
        if (su_inc <= 5'd9) begin
          sec_units_next = su_inc[3:0];
        end else begin
          sec_units_next = 4'd0;
          if (st_inc <= 4'd5) begin
            sec_tens_next = st_inc[2:0];
          end else begin
            sec_tens_next = 3'd0;
            if (mu_inc <= 5'd9) begin
              min_units_next = mu_inc[3:0];
            end else begin
              min_units_next = 4'd0;
              if (mt_inc <= 4'd5) begin
                min_tens_next = mt_inc[2:0];
              end else begin
                min_tens_next = 3'd0;
                hr_units_next = hu_inc[3:0];
                if (hr_tens < 2'd2) begin
                  if (hu_inc > 5'd9) begin
                    hr_units_next = 4'd0;
                    hr_tens_next  = ht_inc[1:0];
                  end
                end else if (hu_inc > 5'd3) begin
                  hr_units_next = 4'd0;
                  hr_tens_next  = 2'd0;
                end
              end
            end
          end
        end
      end
      bcdclk_pkg::KIND_REFRESH: begin
        dot = (scan_pos <= bcdclk_pkg::POS_HR_TEN) && (cursor == scan_pos);
        unique case (scan_pos)
          bcdclk_pkg::POS_MIN_UNIT: begin
            shown = min_units;
            enable_latch_next = bcdclk_pkg::EN_POS0;
            scan_pos_next = bcdclk_pkg::POS_MIN_TEN;
          end
          bcdclk_pkg::POS_MIN_TEN: begin
            shown = {1'b0, min_tens};
            enable_latch_next = bcdclk_pkg::EN_POS1;
            scan_pos_next = bcdclk_pkg::POS_HR_UNIT;
          end
          bcdclk_pkg::POS_HR_UNIT: begin
            shown = hr_units;
            enable_latch_next = bcdclk_pkg::EN_POS2;
            scan_pos_next = bcdclk_pkg::POS_HR_TEN;
          end
          bcdclk_pkg::POS_HR_TEN: begin
            shown = {2'b00, hr_tens};
            enable_latch_next = bcdclk_pkg::EN_POS3;
            scan_pos_next = bcdclk_pkg::POS_MIN_UNIT;
          end
          bcdclk_pkg::POS_SEC_UNIT: begin
            shown = sec_units;
            enable_latch_next = bcdclk_pkg::EN_POS0;
            scan_pos_next = bcdclk_pkg::POS_SEC_TEN;
          end
          bcdclk_pkg::POS_SEC_TEN: begin
            shown = {1'b0, sec_tens};
            enable_latch_next = bcdclk_pkg::EN_POS1;
            scan_pos_next = bcdclk_pkg::POS_SEC_UNIT;
          end
          default: begin
            enable_latch_next = bcdclk_pkg::EN_OFF;
          end
        endcase
        if (scan_pos >= bcdclk_pkg::POS_MIN_UNIT && scan_pos <= bcdclk_pkg::POS_SEC_TEN) begin
          seg_latch_next = bcdclk_pkg::seg_pattern(shown)
                         & ((dot || dot_always_on) ? bcdclk_pkg::SEG_DOT : bcdclk_pkg::SEG_BLANK);
        end
      end
      bcdclk_pkg::KIND_TOGGLE: begin
        scan_pos_next = (scan_pos < bcdclk_pkg::POS_SEC_UNIT)
                      ? bcdclk_pkg::POS_SEC_UNIT : bcdclk_pkg::POS_MIN_UNIT;
      end
      bcdclk_pkg::KIND_CURSOR: begin
        if (item_sel <= bcdclk_pkg::POS_HR_TEN) begin
          cursor_next = item_sel;
          if (item_sel != bcdclk_pkg::POS_NONE && scan_pos >= bcdclk_pkg::POS_SEC_UNIT) begin
            scan_pos_next = bcdclk_pkg::POS_MIN_UNIT;
          end
        end
      end
      bcdclk_pkg::KIND_INC: begin
        unique case (cursor)
          bcdclk_pkg::POS_MIN_UNIT: begin
            min_units_next = (mu_inc > 5'd9) ? 4'd0 : mu_inc[3:0];
          end
          bcdclk_pkg::POS_MIN_TEN: begin
            min_tens_next = (mt_inc > 4'd5) ? 3'd0 : mt_inc[2:0];
          end
          bcdclk_pkg::POS_HR_UNIT: begin
            hr_units_next = ((hr_tens > 2'd1 && hu_inc > 5'd3) || hu_inc > 5'd9)
                          ? 4'd0 : hu_inc[3:0];
          end
          bcdclk_pkg::POS_HR_TEN: begin
            hr_tens_next = ((hr_units > 4'd3 && ht_inc > 3'd1) || ht_inc > 3'd2)
                         ? 2'd0 : ht_inc[1:0];
          end
          default: begin
          end
        endcase
      end
      bcdclk_pkg::KIND_END: begin
        sec_units_next = 4'd0;
        sec_tens_next  = 3'd0;
        cursor_next    = bcdclk_pkg::POS_NONE;
      end
      default: begin
      end
    endcase
  end

  // clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_units    <= 4'd0;
      sec_tens     <= 3'd0;
      min_units    <= 4'd0;
      min_tens     <= 3'd0;
      hr_units     <= 4'd0;
      hr_tens      <= 2'd0;
      scan_pos     <= bcdclk_pkg::POS_MIN_UNIT;
      cursor       <= bcdclk_pkg::POS_NONE;
      seg_latch    <= bcdclk_pkg::SEG_BLANK;
      enable_latch <= bcdclk_pkg::EN_OFF;
    end else if (advance) begin
      sec_units    <= sec_units_next;
      sec_tens     <= sec_tens_next;
      min_units    <= min_units_next;
      min_tens     <= min_tens_next;
      hr_units     <= hr_units_next;
      hr_tens      <= hr_tens_next;
      scan_pos     <= scan_pos_next;
      cursor       <= cursor_next;
      seg_latch    <= seg_latch_next;
      enable_latch <= enable_latch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      segments      <= seg_latch_next;
      digit_enables <= enable_latch_next;
      hour_tens     <= hr_tens_next;
      hour_units    <= hr_units_next;
      minute_tens   <= min_tens_next;
      minute_units  <= min_units_next;
      second_tens   <= sec_tens_next;
      second_units  <= sec_units_next;
      view_seconds  <= (scan_pos_next == bcdclk_pkg::POS_SEC_UNIT) ||
                       (scan_pos_next == bcdclk_pkg::POS_SEC_TEN);
    end
  end

  `BCD_ASSERT(a_digits_in_range,
              sec_units <= 4'd9 && sec_tens <= 3'd5 && min_units <= 4'd9 &&
              min_tens <= 3'd5 && hr_units <= 4'd9,
              "clock digit out of range")
  `BCD_ASSERT(a_hour_limit,
              hr_tens != 2'd3 && (hr_tens != 2'd2 || hr_units <= 4'd3),
              "hours beyond 23")
  `BCD_ASSERT(a_advance_gives_result, advance |=> out_valid,
              "processed item gave no result")
  `BCD_ASSERT(a_held_item_kept,
              in_stall |=> item_valid && $stable(item_kind) && $stable(item_sel),
              "waiting item lost")
  `BCD_ASSERT(a_enables_one_cold,
              $onehot(~enable_latch) || enable_latch == bcdclk_pkg::EN_OFF,
              "more than one digit enabled")
  `BCD_ASSERT(a_scan_in_range,
              scan_pos >= bcdclk_pkg::POS_MIN_UNIT && scan_pos <= bcdclk_pkg::POS_SEC_TEN,
              "scan position out of range")

endmodule
